FILE: sv/nsu_pkg.sv
package nsu_pkg;

    // default sizes, handed to the top level parameters
    localparam int DEF_MAX_DIMS    = 4;
    localparam int DEF_EXTENT_BITS = 16;
    localparam int DEF_VALUE_BITS  = 32;

    // fixed field widths
    localparam int INDEX_BITS       = 64;
    localparam int VALUE_FIELD_BITS = 32;
    localparam int CFG_DATA_BITS    = 64;
    localparam int CFG_INDEX_BITS   = 2;
    localparam int DIMS_FIELD_BITS  = 3;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DIMS_IN_USE    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OPERAND_SHAPE  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UPDATE_SHAPE   = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_POSITION = 2'd3;

    // status of the derivation sequencer
    typedef struct packed {
        logic busy;
        logic empty;
    } t_setup_stat;

    // bits to index one of dim_count dimensions
    function automatic int dim_bits(input int dim_count);
        int bits;
        bits = (dim_count > 1) ? $clog2(dim_count) : 1;
        return bits;
    endfunction

endpackage

FILE: sv/nd_slice_update_address_gen_core.sv
// address generator for a dynamic slice update
// input stream (s_axis): one update element per word, row-major order over the update box
// output stream (m_axis): flat operand index, the element bits and tlast on the final element
// configuration: i_cfg_we writes register i_cfg_index (0 dims in use, 1 operand shape,
//   2 update shape, 3 start position) from i_cfg_data, no read-back
// after reset and after every register write a sequencer derives strides, the clamped
//   base offset and per-dimension index steps through one shared 16 x 64 multiplier;
//   tready stays low while the derivation runs
// the walk restarts at the first element of the update whenever the derivation reruns
// a word accepted on s_axis is written into the queue, then into the output register on m_axis
// throughput: one word per cycle if not busy or stalled; the front counts coordinates and a
//   four-entry queue feeds the back, which adds one precomputed step to the index per word
// a stall on m_axis holds the output register; the queue absorbs up to four more words
//   before s_axis tready drops
// with an empty update (any used extent zero) words are accepted and dropped
// after the final element the counters wrap and the next word starts a new pass
module nd_slice_update_address_gen_core
    import nsu_pkg::*;
#(
    parameter int MAX_DIMS    = DEF_MAX_DIMS,
    parameter int EXTENT_BITS = DEF_EXTENT_BITS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]              i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]               i_cfg_data,
    // update elements in
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  logic [VALUE_FIELD_BITS-1:0]            i_s_axis_tdata,   // update_value
    // target addresses out
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    output logic [INDEX_BITS+VALUE_FIELD_BITS-1:0] o_m_axis_tdata,   // target_index, element_value
    output logic                                   o_m_axis_tlast    // final_element
);

    localparam int DIM_W   = dim_bits(MAX_DIMS);
    localparam int Q_WIDTH = DIM_W + VALUE_FIELD_BITS + 1;

    t_setup_stat                           w_stat;
    logic [DIM_W-1:0]                      w_last_dim;
    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]  w_upd_ext;
    logic [INDEX_BITS-1:0]                 w_base;
    logic [MAX_DIMS-1:0][INDEX_BITS-1:0]   w_delta;

    logic                                  w_push;
    logic [Q_WIDTH-1:0]                    w_push_data;
    logic                                  w_pop;
    logic                                  w_q_valid;
    logic                                  w_q_full;
    logic [Q_WIDTH-1:0]                    w_q_data;

    // derived walk parameters
    nsu_setup #(
        .MAX_DIMS    (MAX_DIMS),
        .EXTENT_BITS (EXTENT_BITS)
    ) u_setup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (w_stat),
        .o_last_dim  (w_last_dim),
        .o_upd_ext   (w_upd_ext),
        .o_base      (w_base),
        .o_delta     (w_delta)
    );

    // coordinate counters, classify each word by the dimension that steps
    nsu_front #(
        .MAX_DIMS    (MAX_DIMS),
        .EXTENT_BITS (EXTENT_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_stat          (w_stat),
        .i_last_dim      (w_last_dim),
        .i_upd_ext       (w_upd_ext),
        .i_q_full        (w_q_full),
        .o_push          (w_push),
        .o_push_data     (w_push_data)
    );

    nsu_queue #(
        .WIDTH (Q_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_valid     (w_q_valid),
        .o_full      (w_q_full),
        .o_data      (w_q_data)
    );

    // index accumulator and output register
    nsu_back #(
        .MAX_DIMS (MAX_DIMS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_stat          (w_stat),
        .i_base          (w_base),
        .i_delta         (w_delta),
        .i_q_valid       (w_q_valid),
        .i_q_data        (w_q_data),
        .o_pop           (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

FILE: sv/nsu_setup.sv
module nsu_setup
    import nsu_pkg::*;
#(
    parameter int MAX_DIMS    = DEF_MAX_DIMS,
    parameter int EXTENT_BITS = DEF_EXTENT_BITS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]               i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]                i_cfg_data,
    output t_setup_stat                             o_stat,
    output logic [dim_bits(MAX_DIMS)-1:0]           o_last_dim,
    output logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]    o_upd_ext,
    output logic [INDEX_BITS-1:0]                   o_base,
    output logic [MAX_DIMS-1:0][INDEX_BITS-1:0]     o_delta
);

    localparam int DIM_W = dim_bits(MAX_DIMS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INIT = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_ACC  = 2'd3;

    localparam logic [1:0] OP_BASE   = 2'd0;
    localparam logic [1:0] OP_SPAN   = 2'd1;
    localparam logic [1:0] OP_STRIDE = 2'd2;

    logic [DIMS_FIELD_BITS-1:0] r_dims;
    logic [CFG_DATA_BITS-1:0]   r_op_shape;
    logic [CFG_DATA_BITS-1:0]   r_upd_shape;
    logic [CFG_DATA_BITS-1:0]   r_start;

    logic [1:0]                 r_state;
    logic [1:0]                 r_op;
    logic [DIM_W-1:0]           r_dim;
    logic [INDEX_BITS-1:0]      r_prod;
    logic [INDEX_BITS-1:0]      r_base;
    logic [INDEX_BITS-1:0]      r_span;
    logic [INDEX_BITS-1:0]      r_stride [MAX_DIMS];
    logic [INDEX_BITS-1:0]      r_delta  [MAX_DIMS];

    logic [EXTENT_BITS-1:0]     w_op_ext [MAX_DIMS];
    logic [EXTENT_BITS-1:0]     w_upd    [MAX_DIMS];
    logic [EXTENT_BITS-1:0]     w_clamp  [MAX_DIMS];
    logic [DIM_W-1:0]           w_last_dim;
    logic                       w_empty;
    logic [EXTENT_BITS-1:0]     w_mul_a;
    logic [EXTENT_BITS+INDEX_BITS-1:0] w_mul_full;

    // unpack extents, clamp start per dimension
    always_comb begin
        logic [EXTENT_BITS-1:0] raw;
        logic signed [EXTENT_BITS+1:0] s;
        logic signed [EXTENT_BITS+1:0] hi;
        for (int d = 0; d < MAX_DIMS; d++) begin
            w_op_ext[d] = r_op_shape[(MAX_DIMS-1-d)*EXTENT_BITS +: EXTENT_BITS];
            w_upd[d]    = r_upd_shape[(MAX_DIMS-1-d)*EXTENT_BITS +: EXTENT_BITS];
            raw         = r_start[(MAX_DIMS-1-d)*EXTENT_BITS +: EXTENT_BITS];
            s  = $signed({{2{raw[EXTENT_BITS-1]}}, raw});
            hi = $signed({2'b00, w_op_ext[d]}) - $signed({2'b00, w_upd[d]});
            if (s < 0) begin
                s = '0;
            end
            if (s > hi) begin
                s = hi;
            end
            if (s < 0) begin
                s = '0;
            end
            w_clamp[d] = s[EXTENT_BITS-1:0];
        end
    end

    // dimension count, zero counts as one, values above MAX_DIMS count as MAX_DIMS
    always_comb begin
        if (r_dims == '0) begin
            w_last_dim = '0;
        end else if (r_dims > DIMS_FIELD_BITS'(MAX_DIMS)) begin
            w_last_dim = DIM_W'(MAX_DIMS - 1);
        end else begin
            w_last_dim = DIM_W'(r_dims - 1'b1);
        end
    end

    always_comb begin
        w_empty = 1'b0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (DIM_W'(d) <= w_last_dim && w_upd[d] == '0) begin
                w_empty = 1'b1;
            end
        end
    end

    // shared multiplier operand
    always_comb begin
        unique case (r_op)
            OP_BASE:   w_mul_a = w_clamp[r_dim];
            OP_SPAN:   w_mul_a = w_upd[r_dim] - 1'b1;
            OP_STRIDE: w_mul_a = w_op_ext[r_dim];
            default:   w_mul_a = '0;
        endcase
    end

    assign w_mul_full = w_mul_a * r_stride[r_dim];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims      <= DIMS_FIELD_BITS'(1);
            r_op_shape  <= '0;
            r_upd_shape <= '0;
            r_start     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DIMS_IN_USE:    r_dims      <= i_cfg_data[DIMS_FIELD_BITS-1:0];
                CFG_OPERAND_SHAPE:  r_op_shape  <= i_cfg_data;
                CFG_UPDATE_SHAPE:   r_upd_shape <= i_cfg_data;
                CFG_START_POSITION: r_start     <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_op    <= OP_BASE;
            r_dim   <= '0;
        end else if (i_cfg_we) begin
            r_state <= ST_INIT;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                end
                ST_INIT: begin
                    for (int d = 0; d < MAX_DIMS; d++) begin
                        r_stride[d] <= (DIM_W'(d) == w_last_dim) ? INDEX_BITS'(1) : '0;
                    end
                    r_base  <= '0;
                    r_span  <= '0;
                    r_dim   <= w_last_dim;
                    r_op    <= OP_BASE;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_prod  <= w_mul_full[INDEX_BITS-1:0];
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    unique case (r_op)
                        OP_BASE: begin
                            r_base  <= r_base + r_prod;
                            r_op    <= OP_SPAN;
                            r_state <= ST_MUL;
                        end
                        OP_SPAN: begin
                            // step into this dimension undoes the wraps of all inner ones
                            r_delta[r_dim] <= r_stride[r_dim] - r_span;
                            r_span         <= r_span + r_prod;
                            if (r_dim == '0) begin
                                r_state <= ST_IDLE;
                            end else begin
                                r_op    <= OP_STRIDE;
                                r_state <= ST_MUL;
                            end
                        end
                        OP_STRIDE: begin
                            r_stride[DIM_W'(r_dim - 1'b1)] <= r_prod;
                            r_dim   <= DIM_W'(r_dim - 1'b1);
                            r_op    <= OP_BASE;
                            r_state <= ST_MUL;
                        end
                        default: begin
                            r_state <= ST_IDLE;
                        end
                    endcase
                end
            endcase
        end
    end

    always_comb begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            o_upd_ext[d] = w_upd[d];
            o_delta[d]   = r_delta[d];
        end
    end

    assign o_stat.busy  = (r_state != ST_IDLE);
    assign o_stat.empty = w_empty;
    assign o_last_dim   = w_last_dim;
    assign o_base       = r_base;

endmodule

FILE: sv/nsu_front.sv
module nsu_front
    import nsu_pkg::*;
#(
    parameter int MAX_DIMS    = DEF_MAX_DIMS,
    parameter int EXTENT_BITS = DEF_EXTENT_BITS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    input  logic [VALUE_FIELD_BITS-1:0]                 i_s_axis_tdata,
    input  t_setup_stat                                 i_stat,
    input  logic [dim_bits(MAX_DIMS)-1:0]               i_last_dim,
    input  logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]        i_upd_ext,
    input  logic                                        i_q_full,
    output logic                                        o_push,
    output logic [dim_bits(MAX_DIMS)+VALUE_FIELD_BITS:0] o_push_data
);

    localparam int DIM_W = dim_bits(MAX_DIMS);
    localparam logic [VALUE_FIELD_BITS:0] VALUE_MASK_W =
        (({{VALUE_FIELD_BITS{1'b0}}, 1'b1}) << VALUE_BITS) - 1'b1;

    logic [EXTENT_BITS-1:0] r_coord [MAX_DIMS];
    logic [MAX_DIMS-1:0]    w_wrap;
    logic [MAX_DIMS-1:0]    w_used;
    logic                   w_last;
    logic [DIM_W-1:0]       w_step;
    logic                   w_accept;

    always_comb begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            w_used[d] = (DIM_W'(d) <= i_last_dim);
            w_wrap[d] = (({1'b0, r_coord[d]} + 1'b1) == {1'b0, i_upd_ext[d]});
        end
    end

    // innermost dimension that does not wrap takes the increment
    always_comb begin
        w_step = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (w_used[d] && !w_wrap[d]) begin
                w_step = DIM_W'(d);
            end
        end
    end

    assign w_last          = &(w_wrap | ~w_used);
    assign o_s_axis_tready = !i_stat.busy && !i_q_full;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_push          = w_accept && !i_stat.empty;
    assign o_push_data     = {w_step, w_last,
                              i_s_axis_tdata & VALUE_MASK_W[VALUE_FIELD_BITS-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_stat.busy) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_coord[d] <= '0;
            end
        end else if (o_push) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                if (w_used[d]) begin
                    if (w_last || DIM_W'(d) > w_step) begin
                        r_coord[d] <= '0;
                    end else if (DIM_W'(d) == w_step) begin
                        r_coord[d] <= r_coord[d] + 1'b1;
                    end
                end
            end
        end
    end

endmodule

FILE: sv/nsu_queue.sv
module nsu_queue
    import nsu_pkg::*;
#(
    parameter int WIDTH = VALUE_FIELD_BITS,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue fill count did not follow a write");

endmodule

FILE: sv/nsu_back.sv
module nsu_back
    import nsu_pkg::*;
#(
    parameter int MAX_DIMS = DEF_MAX_DIMS
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  t_setup_stat                                 i_stat,
    input  logic [INDEX_BITS-1:0]                       i_base,
    input  logic [MAX_DIMS-1:0][INDEX_BITS-1:0]         i_delta,
    input  logic                                        i_q_valid,
    input  logic [dim_bits(MAX_DIMS)+VALUE_FIELD_BITS:0] i_q_data,
    output logic                                        o_pop,
    output logic                                        o_m_axis_tvalid,
    input  logic                                        i_m_axis_tready,
    output logic [INDEX_BITS+VALUE_FIELD_BITS-1:0]      o_m_axis_tdata,
    output logic                                        o_m_axis_tlast
);

    localparam int DIM_W = dim_bits(MAX_DIMS);

    logic [INDEX_BITS-1:0]       r_walk;
    logic                        r_tvalid;
    logic [INDEX_BITS-1:0]       r_index;
    logic [VALUE_FIELD_BITS-1:0] r_value;
    logic                        r_last;

    logic [VALUE_FIELD_BITS-1:0] w_value;
    logic                        w_last;
    logic [DIM_W-1:0]            w_step;

    assign w_value = i_q_data[VALUE_FIELD_BITS-1:0];
    assign w_last  = i_q_data[VALUE_FIELD_BITS];
    assign w_step  = i_q_data[VALUE_FIELD_BITS+DIM_W:VALUE_FIELD_BITS+1];

    // output register refills whenever it is empty or being taken
    assign o_pop = i_q_valid && (!r_tvalid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
        end else if (o_pop) begin
            r_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_stat.busy) begin
            r_walk <= i_base;
        end else if (o_pop) begin
            r_walk <= w_last ? i_base : r_walk + i_delta[w_step];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_index <= r_walk;
            r_value <= w_value;
            r_last  <= w_last;
        end
    end

    assign o_m_axis_tvalid = r_tvalid;
    assign o_m_axis_tdata  = {r_value, r_index};
    assign o_m_axis_tlast  = r_last;

    a_walk_starts_at_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_stat.busy) |-> r_walk == i_base)
        else $error("walk does not start at the base offset");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

// self-checking bench for nd_slice_update_address_gen_core
module tb
    import nsu_pkg::*;
();

    localparam int RESET_CYCLES = 12;
    // output latency plus the four-entry queue, with some margin
    localparam int TAIL_CYCLES  = 10;
    // cycles with no word moving and no register write before giving up
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_WORDS = 500;
    localparam int DIMS         = DEF_MAX_DIMS;
    localparam int EXT_W        = DEF_EXTENT_BITS;

    // one landing of an update element: where it goes, what it carries
    typedef struct packed {
        logic [INDEX_BITS-1:0]       index;
        logic [VALUE_FIELD_BITS-1:0] value;
        logic                        last;
    } t_landing;

    typedef enum logic [1:0] {
        ROW_WRITE,         // register write
        ROW_WORD,          // update word, landing worked out by the predictor
        ROW_WORD_AT,       // update word, landing typed into the row
        ROW_WORD_DROPPED   // update word into an empty update, nothing comes out
    } t_row_kind;

    typedef struct {
        t_row_kind                 kind;
        logic [CFG_INDEX_BITS-1:0] reg_idx;   // ignored on word rows
        logic [CFG_DATA_BITS-1:0]  data;      // register value, or the word in the low bits
        logic [INDEX_BITS-1:0]     at_index;
        logic                      at_last;
    } t_row;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // configuration port
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_DIMS_IN_USE;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // update words in
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [VALUE_FIELD_BITS-1:0] s_tdata  = '0;   // update_value

    // landings out
    logic                                   m_tvalid;
    logic                                   m_tready = 1'b0;
    logic [INDEX_BITS+VALUE_FIELD_BITS-1:0] m_tdata;   // target_index, element_value
    logic                                   m_tlast;   // final_element

    nd_slice_update_address_gen_core u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    // landings still owed by the block, oldest first
    t_landing landings [$];
    int       err_cnt   = 0;
    int       fed_words = 0;

    // predictor: register copies
    logic [DIMS_FIELD_BITS-1:0] pr_dims;
    logic [CFG_DATA_BITS-1:0]   pr_op_shape;
    logic [CFG_DATA_BITS-1:0]   pr_upd_shape;
    logic [CFG_DATA_BITS-1:0]   pr_start;

    // predictor: derived state and walk position
    int                    pr_used;
    logic                  pr_empty;
    logic [63:0]           pr_upd_ext [DIMS];
    logic [63:0]           pr_stride  [DIMS];
    logic [EXT_W-1:0]      pr_coord   [DIMS];
    logic [INDEX_BITS-1:0] pr_base;
    logic [INDEX_BITS-1:0] pr_cur;

    // directed part: typed landings only where they are obvious by hand
    t_row dir_rows [0:35] = '{
        // empty update straight out of reset
        '{ROW_WORD_DROPPED, CFG_DIMS_IN_USE, 64'h0000_0000_FFFF_FFFF, 64'd0, 1'b0},
        // 3 x 4 operand, 2 x 2 update, start (1, -1) clamps to (1, 0): base 4
        '{ROW_WRITE, CFG_DIMS_IN_USE,    64'd2,                  64'd0, 1'b0},
        '{ROW_WRITE, CFG_OPERAND_SHAPE,  64'h0003_0004_0000_0000, 64'd0, 1'b0},
        '{ROW_WRITE, CFG_UPDATE_SHAPE,   64'h0002_0002_0000_0000, 64'd0, 1'b0},
        '{ROW_WRITE, CFG_START_POSITION, 64'h0001_FFFF_0000_0000, 64'd0, 1'b0},
        '{ROW_WORD_AT, CFG_DIMS_IN_USE, 64'h0000_0000_0000_0000, 64'd4, 1'b0},
        '{ROW_WORD_AT, CFG_DIMS_IN_USE, 64'h0000_0000_FFFF_FFFF, 64'd5, 1'b0},
        '{ROW_WORD_AT, CFG_DIMS_IN_USE, 64'h0000_0000_5555_5555, 64'd8, 1'b0},
        '{ROW_WORD_AT, CFG_DIMS_IN_USE, 64'h0000_0000_AAAA_AAAA, 64'd9, 1'b1},
        // wraps round to a second pass, then is left mid-walk
        '{ROW_WORD_AT, CFG_DIMS_IN_USE, 64'h0000_0000_1234_5678, 64'd4, 1'b0},
        '{ROW_WORD_AT, CFG_DIMS_IN_USE, 64'h0000_0000_8000_0001, 64'd5, 1'b0},
        // dims above the maximum, whole-tensor update at the largest extents
        '{ROW_WRITE, CFG_DIMS_IN_USE,    64'd7,                  64'd0, 1'b0},
        '{ROW_WRITE, CFG_OPERAND_SHAPE,  64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b0},
        '{ROW_WRITE, CFG_UPDATE_SHAPE,   64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b0},
        '{ROW_WRITE, CFG_START_POSITION, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b0},
        '{ROW_WORD_AT, CFG_DIMS_IN_USE, 64'h0000_0000_0000_FFFF, 64'd0, 1'b0},
        '{ROW_WORD_AT, CFG_DIMS_IN_USE, 64'h0000_0000_FFFF_0000, 64'd1, 1'b0},
        // tiny box deep in a huge operand, most positive and most negative starts
        '{ROW_WRITE, CFG_UPDATE_SHAPE,   64'h0001_0001_0001_0002, 64'd0, 1'b0},
        '{ROW_WRITE, CFG_START_POSITION, 64'h7FFF_8000_FFFF_7FFF, 64'd0, 1'b0},
        '{ROW_WORD, CFG_DIMS_IN_USE, 64'h0000_0000_0F0F_0F0F, 64'd0, 1'b0},
        '{ROW_WORD, CFG_DIMS_IN_USE, 64'h0000_0000_F0F0_F0F0, 64'd0, 1'b0},
        // zero dims counts as one, update wider than operand forces start 0
        '{ROW_WRITE, CFG_DIMS_IN_USE,    64'd0,                  64'd0, 1'b0},
        '{ROW_WRITE, CFG_OPERAND_SHAPE,  64'h0005_FFFF_FFFF_FFFF, 64'd0, 1'b0},
        '{ROW_WRITE, CFG_UPDATE_SHAPE,   64'h0007_0000_0000_0000, 64'd0, 1'b0},
        '{ROW_WRITE, CFG_START_POSITION, 64'h0003_8000_7FFF_0000, 64'd0, 1'b0},
        '{ROW_WORD_AT, CFG_DIMS_IN_USE, 64'h0000_0000_0000_0001, 64'd0, 1'b0},
        '{ROW_WORD_AT, CFG_DIMS_IN_USE, 64'h0000_0000_0000_0002, 64'd1, 1'b0},
        // start 3 pulled back to 2 by the upper clamp
        '{ROW_WRITE, CFG_UPDATE_SHAPE,   64'h0003_0000_0000_0000, 64'd0, 1'b0},
        '{ROW_WORD, CFG_DIMS_IN_USE, 64'h0000_0000_0000_0003, 64'd0, 1'b0},
        '{ROW_WORD, CFG_DIMS_IN_USE, 64'h0000_0000_0000_0004, 64'd0, 1'b0},
        '{ROW_WORD, CFG_DIMS_IN_USE, 64'h0000_0000_0000_0005, 64'd0, 1'b0},
        // zero extent inside the used dimensions empties the update
        '{ROW_WRITE, CFG_DIMS_IN_USE,    64'd3,                  64'd0, 1'b0},
        '{ROW_WRITE, CFG_OPERAND_SHAPE,  64'h0003_0003_0003_0000, 64'd0, 1'b0},
        '{ROW_WRITE, CFG_UPDATE_SHAPE,   64'h0001_0002_0000_0003, 64'd0, 1'b0},
        '{ROW_WORD_DROPPED, CFG_DIMS_IN_USE, 64'h0000_0000_DEAD_BEEF, 64'd0, 1'b0},
        '{ROW_WORD_DROPPED, CFG_DIMS_IN_USE, 64'h0000_0000_0000_0000, 64'd0, 1'b0}
    };

    function automatic void note_failure(input string what);
        err_cnt++;
        if (err_cnt <= 10) $display("mismatch at %0t: %s", $time, what);
    endfunction

    // dimension 0 sits in the top field
    function automatic logic [EXT_W-1:0] extent_of(input logic [63:0] shape, input int d);
        return shape[(DIMS - 1 - d) * EXT_W +: EXT_W];
    endfunction

    // strides, clamped base and a fresh walk from the register copies
    function automatic void rederive();
        logic [63:0]              op_ext [DIMS];
        logic signed [EXT_W-1:0]  raw;
        longint                   first;
        longint                   limit;
        int                       n;
        n = int'(pr_dims);
        if (n < 1) n = 1;
        if (n > DIMS) n = DIMS;
        pr_used  = n;
        pr_empty = 1'b0;
        for (int d = 0; d < DIMS; d++) begin
            op_ext[d]     = 64'(extent_of(pr_op_shape, d));
            pr_upd_ext[d] = 64'(extent_of(pr_upd_shape, d));
            pr_stride[d]  = '0;
            pr_coord[d]   = '0;
        end
        pr_stride[n-1] = 64'd1;
        for (int d = n - 1; d > 0; d--) pr_stride[d-1] = pr_stride[d] * op_ext[d];
        pr_base = '0;
        for (int d = 0; d < n; d++) begin
            raw   = extent_of(pr_start, d);
            first = raw;
            limit = longint'(op_ext[d]) - longint'(pr_upd_ext[d]);
            // negative start to 0, then pull back into the operand, 0 if it cannot fit
            if (first < 0) first = 0;
            if (first > limit) first = limit;
            if (first < 0) first = 0;
            pr_base = pr_base + 64'(first) * pr_stride[d];
            if (pr_upd_ext[d] == 64'd0) pr_empty = 1'b1;
        end
        pr_cur = pr_base;
    endfunction

    // landing of the next update element; advances the carry chain
    function automatic bit land_element(input logic [31:0] v, output t_landing r);
        bit fin;
        bit carry;
        int d;
        r = '0;
        if (pr_empty) return 1'b0;
        fin = 1'b1;
        for (int k = 0; k < pr_used; k++)
            if (64'(pr_coord[k]) != pr_upd_ext[k] - 64'd1) fin = 1'b0;
        r.index = pr_cur;
        r.value = v;
        r.last  = fin;
        d     = pr_used;
        carry = 1'b1;
        while (carry && d > 0) begin
            d--;
            pr_coord[d] = pr_coord[d] + 1'b1;
            pr_cur      = pr_cur + pr_stride[d];
            if (64'(pr_coord[d]) < pr_upd_ext[d]) begin
                carry = 1'b0;
            end else begin
                // dimension rolls over: step back to its start
                pr_coord[d] = '0;
                pr_cur      = pr_cur - pr_upd_ext[d] * pr_stride[d];
            end
        end
        return 1'b1;
    endfunction

    // idle stretch: mostly none or short, now and then long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // one register write, mirrored into the predictor
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_DIMS_IN_USE:    pr_dims      = val[DIMS_FIELD_BITS-1:0];
            CFG_OPERAND_SHAPE:  pr_op_shape  = val;
            CFG_UPDATE_SHAPE:   pr_upd_shape = val;
            CFG_START_POSITION: pr_start     = val;
            default: ;
        endcase
        rederive();
    endtask

    // offer one word after a random gap; returns at the edge that takes it
    task automatic send_word(input logic [31:0] v);
        int gap;
        gap = idle_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;   // junk on the bus while idle
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge clk); while (s_tready !== 1'b1);
    endtask

    // let every owed landing out, then give dropped words time to clear
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (landings.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic run_directed();
        t_landing r;
        bit       made;
        for (int i = 0; i < $size(dir_rows); i++) begin
            if (dir_rows[i].kind == ROW_WRITE) begin
                if (i > 0 && dir_rows[i-1].kind != ROW_WRITE) wait_drained();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].data);
            end else begin
                send_word(dir_rows[i].data[31:0]);
                made = land_element(dir_rows[i].data[31:0], r);
                case (dir_rows[i].kind)
                    ROW_WORD_AT: begin
                        r.index = dir_rows[i].at_index;
                        r.value = dir_rows[i].data[31:0];
                        r.last  = dir_rows[i].at_last;
                        landings.push_back(r);
                    end
                    ROW_WORD: begin
                        if (made) landings.push_back(r);
                    end
                    default: ;
                endcase
            end
        end
    endtask

    // one random setting followed by enough words for a pass or two
    task automatic random_phase();
        logic [63:0]                op_v;
        logic [63:0]                upd_v;
        logic [63:0]                st_v;
        logic [EXT_W-1:0]           oe;
        logic [EXT_W-1:0]           ue;
        logic [EXT_W-1:0]           se;
        logic [DIMS_FIELD_BITS-1:0] dims_v;
        logic [31:0]                v;
        t_landing                   r;
        int                         umax;
        int                         ue_hi;
        int                         cells;
        int                         words;
        int                         pick;
        wait_drained();
        pick = $urandom_range(0, 9);
        if (pick == 0)
            dims_v = '0;
        else if (pick == 1)
            dims_v = DIMS_FIELD_BITS'($urandom_range(5, 7));
        else
            dims_v = DIMS_FIELD_BITS'($urandom_range(1, 4));
        write_reg(CFG_DIMS_IN_USE, CFG_DATA_BITS'(dims_v));
        // unused fields keep random junk, the block must ignore them
        op_v  = {$urandom, $urandom};
        upd_v = {$urandom, $urandom};
        st_v  = {$urandom, $urandom};
        // keep the box small so passes complete and wrap
        umax  = (pr_used == 1) ? 8 : (pr_used == 2) ? 4 : (pr_used == 3) ? 3 : 2;
        cells = 1;
        for (int d = 0; d < pr_used; d++) begin
            if ($urandom_range(0, 7) == 0)
                oe = EXT_W'($urandom_range(0, 65535));
            else
                oe = EXT_W'($urandom_range(1, 6));
            ue_hi = (int'(oe) < umax) ? int'(oe) : umax;
            if (ue_hi < 1) ue_hi = 1;
            case ($urandom_range(0, 19))
                0:       ue = '0;                                     // empty update
                1, 2:    ue = oe + EXT_W'($urandom_range(1, 2));     // wider than operand
                default: ue = EXT_W'($urandom_range(1, ue_hi));
            endcase
            case ($urandom_range(0, 5))
                0:       se = EXT_W'($urandom);
                1:       se = 16'h8000 | EXT_W'($urandom);            // negative start
                default: se = EXT_W'($urandom_range(0, int'(oe)));
            endcase
            op_v[(DIMS - 1 - d) * EXT_W +: EXT_W]  = oe;
            upd_v[(DIMS - 1 - d) * EXT_W +: EXT_W] = ue;
            st_v[(DIMS - 1 - d) * EXT_W +: EXT_W]  = se;
            cells = cells * int'(ue);
            if (cells > 64) cells = 64;
        end
        write_reg(CFG_OPERAND_SHAPE, op_v);
        write_reg(CFG_UPDATE_SHAPE, upd_v);
        write_reg(CFG_START_POSITION, st_v);
        if (cells == 0)
            words = 3;
        else
            words = cells * $urandom_range(1, 2) + $urandom_range(0, 3);
        if (words > 80) words = 80;
        for (int i = 0; i < words; i++) begin
            v = $urandom;
            send_word(v);
            if (land_element(v, r)) landings.push_back(r);
        end
        // dropped words do not count towards the total
        if (cells != 0) fed_words += words;
    endtask

    // sink readiness: ready runs broken by stalls
    int unsigned ready_left = 0;

    always @(posedge clk) begin
        if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else if (m_tready) begin
            m_tready   <= 1'b0;
            ready_left <= idle_len();
        end else begin
            m_tready   <= 1'b1;
            ready_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(0, 15);
        end
    end

    // landing checker
    always @(posedge clk) begin
        t_landing seen;
        t_landing want;
        if (rst_n && m_tvalid && m_tready) begin
            seen.index = m_tdata[INDEX_BITS-1:0];
            seen.value = m_tdata[INDEX_BITS +: VALUE_FIELD_BITS];
            seen.last  = m_tlast;
            if (landings.size() == 0) begin
                note_failure($sformatf("word with nothing owed: index %h value %h last %b",
                                       seen.index, seen.value, seen.last));
            end else begin
                want = landings.pop_front();
                if (seen.index !== want.index || seen.value !== want.value ||
                    seen.last !== want.last)
                    note_failure($sformatf(
                        "index %h/%h value %h/%h last %b/%b (expected/actual)",
                        want.index, seen.index, want.value, seen.value,
                        want.last, seen.last));
            end
        end
    end

    // watchdog on cycles where nothing moves
    int quiet = 0;

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // main sequence
    initial begin
        // register state after reset
        pr_dims      = DIMS_FIELD_BITS'(1);
        pr_op_shape  = '0;
        pr_upd_shape = '0;
        pr_start     = '0;
        rederive();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (TAIL_CYCLES) @(posedge clk);
        run_directed();
        while (fed_words < RANDOM_WORDS) random_phase();
        wait_drained();
        if (err_cnt == 0 && landings.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: nd_slice_update_address_gen_core.f
sv/nsu_pkg.sv
sv/nsu_setup.sv
sv/nsu_front.sv
sv/nsu_queue.sv
sv/nsu_back.sv
sv/nd_slice_update_address_gen_core.sv
sim/tb.sv
